// ===== rtl/core/abvrp_pkg.sv =====
`default_nettype none
package abvrp_pkg;

  localparam int PIXEL_STORE_DEPTH = 65536;
  localparam int VISIBLE_ROWS      = 231;
  localparam int SKIPPED_TOP_ROWS  = 25;
  localparam int SHADOW_DEPTH      = 512;

  localparam int ADDR_W = $clog2(PIXEL_STORE_DEPTH);
  localparam int ROW_W  = 10;  // wide enough for a flipped row before masking

  // Result kinds
  localparam logic [1:0] RK_PLOT    = 2'd0;
  localparam logic [1:0] RK_READ    = 2'd1;
  localparam logic [1:0] RK_HANDLED = 2'd2;
  localparam logic [1:0] RK_FOREIGN = 2'd3;

  // Request kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Opcodes at the previous program counter
  localparam logic [7:0] OPC_STA_INDEXED = 8'h81;
  localparam logic [7:0] OPC_LDA_INDEXED = 8'ha1;

  // Bus map
  localparam logic [15:0] THIRD_LO     = 16'h0400;
  localparam logic [15:0] THIRD_HI     = 16'h05ff;
  localparam logic [15:0] THIRD_BASE   = 16'h0401;
  localparam logic [15:0] VRAM_LO      = 16'h0640;
  localparam logic [15:0] PACKED_HI    = 16'h3fff;
  localparam logic [15:0] FLIP_ADDR    = 16'h4800;
  localparam logic [15:0] DIRECT_LO    = 16'h5000;
  localparam logic [15:0] UPPER_LO     = 16'hf800;
  localparam logic [15:0] READ_LO      = 16'h1900;
  localparam logic [15:0] READ_HI      = 16'hfff9;

endpackage
`default_nettype wire

// ===== rtl/core/abvrp_if.sv =====
`default_nettype none
interface abvrp_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] bus_address;
  logic [7:0]  write_data;
  logic [7:0]  prior_opcode;

  modport source (output valid, kind, bus_address, write_data, prior_opcode, input ready);
  modport sink   (input valid, kind, bus_address, write_data, prior_opcode, output ready);
endinterface

interface abvrp_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        result_kind;
  logic [7:0]        pixel_x;
  logic signed [8:0] pixel_row;
  logic [2:0]        pixel_color;
  logic              on_screen;
  logic [7:0]        read_data;
  logic              last_result;

  modport source (output valid, result_kind, pixel_x, pixel_row, pixel_color, on_screen,
                  read_data, last_result, input ready);
  modport sink   (input valid, result_kind, pixel_x, pixel_row, pixel_color, on_screen,
                  read_data, last_result, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/arcade_bitmap_video_ram_port_unit.sv =====
`default_nettype none
// A request is taken while idle; its first pixel is read into the memory output register,
// then its first result is registered. Throughput: one result per cycle while results are
// taken, set by the single read and single write port of the pixel memory, visited once per
// pixel; no new request is taken before the current one's last result is registered.
// Reset: synchronous; the flip flag clears, then a clearing pass zeroes the 65536 entries of
// the pixel memory one entry per cycle, during which no request is taken.
module arcade_bitmap_video_ram_port_unit
  import abvrp_pkg::*;
(
  input  wire             clk,
  input  wire             rst,
  abvrp_in_if.sink        request,
  abvrp_out_if.source     result
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_WORK} state_t;
  typedef enum logic [2:0] {OP_THIRD, OP_DIRECT, OP_PACKED, OP_READ, OP_SIMPLE} op_t;

  state_t              state;
  op_t                 op;
  logic [ADDR_W-1:0]   addr;      // current pixel; the clearing pass reuses it
  logic [2:0]          cnt;       // pixel index within the request
  logic [2:0]          last_idx;
  logic [7:0]          wdata;
  logic                upper;     // direct or packed target at 0xf800 and up
  logic [1:0]          simple_kind;
  logic                flip;

  // Pixel memory: one read and one write port, registered read data
  logic [2:0]          pix_mem [PIXEL_STORE_DEPTH];
  logic [ADDR_W-1:0]   rd_addr;
  logic [2:0]          mem_q;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_wa;
  logic [2:0]          mem_wd;

  // Output register
  logic                out_valid;
  logic [1:0]          out_kind;
  logic [7:0]          out_x;
  logic signed [8:0]   out_row;
  logic [2:0]          out_color;
  logic                out_on;
  logic [7:0]          out_rdata;
  logic                out_last;

  // Request decode
  op_t                 dec_op;
  logic [ADDR_W-1:0]   dec_addr;
  logic [2:0]          dec_last;
  logic [1:0]          dec_kind;
  logic                dec_flip_wr;
  logic [15:0]         a;
  logic                accept;

  // Pixel step
  logic                fire;
  logic                is_last;
  logic [2:0]          new_pix;
  logic                do_write;
  logic signed [ROW_W-1:0] y;
  logic signed [ROW_W-1:0] row;
  logic                keep_low;
  logic [2:0]          pen;
  logic                on_scr;

  assign a      = request.bus_address;
  assign accept = request.valid && request.ready;
  assign request.ready = (state == S_IDLE);

  always_comb begin
    dec_op      = OP_SIMPLE;
    dec_addr    = a;
    dec_last    = 3'd0;
    dec_kind    = RK_FOREIGN;
    dec_flip_wr = 1'b0;
    if (request.kind == KIND_READ) begin
      if (request.prior_opcode == OPC_LDA_INDEXED && a >= READ_LO && a <= READ_HI) begin
        dec_op = OP_READ;
      end
    end else if (a >= THIRD_LO && a <= THIRD_HI) begin
      // eight pixels per shadow byte, one per data bit, laid out from 0xf800
      dec_op   = OP_THIRD;
      dec_addr = {a[13:0] - THIRD_BASE[13:0], 2'b00} + UPPER_LO;
      dec_last = 3'd7;
    end else if (a >= DIRECT_LO || (a >= VRAM_LO && request.prior_opcode == OPC_STA_INDEXED))
    begin
      dec_op = OP_DIRECT;
    end else if (a >= VRAM_LO && a <= PACKED_HI) begin
      dec_op   = OP_PACKED;
      dec_addr = {a[13:0], 2'b00};
      dec_last = 3'd3;
    end else if (a == FLIP_ADDR) begin
      dec_kind    = RK_HANDLED;
      dec_flip_wr = 1'b1;
    end
  end

  // Advance one pixel whenever the output register is free or being emptied
  assign fire    = (state == S_WORK) && (!out_valid || result.ready);
  assign is_last = (cnt == last_idx);

  always_comb begin
    new_pix  = mem_q;
    do_write = 1'b0;
    case (op)
      OP_THIRD: begin
        new_pix  = {mem_q[2:1], wdata[cnt]};
        do_write = 1'b1;
      end
      OP_DIRECT: begin
        new_pix  = wdata[7:5] | {2'b00, upper & mem_q[0]};
        do_write = 1'b1;
      end
      OP_PACKED: begin
        new_pix  = {wdata[7], wdata[3], upper};
        do_write = 1'b1;
      end
      default: begin
        new_pix  = mem_q;
        do_write = 1'b0;
      end
    endcase
  end

  // Screen position and pen for the current pixel
  always_comb begin
    y        = $signed({2'b00, addr[15:8]}) - ROW_W'(SKIPPED_TOP_ROWS);
    keep_low = !(y < ROW_W'(VISIBLE_ROWS - 32));
    pen      = keep_low ? new_pix : {new_pix[2:1], 1'b0};
    row      = flip ? ROW_W'(VISIBLE_ROWS - 1) - y : y;
    on_scr   = !row[ROW_W-1] && (row < ROW_W'(VISIBLE_ROWS));
  end

  // Read the next pixel while the current one is written back; the last reads its own entry
  always_comb begin
    if (state == S_IDLE) begin
      rd_addr = dec_addr;
    end else if (fire && !is_last) begin
      rd_addr = addr + ADDR_W'(1);
    end else begin
      rd_addr = addr;
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr;
    mem_wd = new_pix;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wd = 3'd0;
    end else if (fire && do_write) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pix_mem[mem_wa] <= mem_wd;
    end
    mem_q <= pix_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      addr      <= '0;
      cnt       <= '0;
      flip      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // drop the result once taken, unless the next one replaces it
      if (result.ready && !fire) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          addr <= addr + ADDR_W'(1);
          if (addr == ADDR_W'(PIXEL_STORE_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state       <= S_WORK;
            op          <= dec_op;
            addr        <= dec_addr;
            cnt         <= '0;
            last_idx    <= dec_last;
            wdata       <= request.write_data;
            upper       <= (dec_addr >= UPPER_LO);
            simple_kind <= dec_kind;
            if (dec_flip_wr) begin
              flip <= !request.write_data[6];
            end
          end
        end
        S_WORK: begin
          if (fire) begin
            out_valid <= 1'b1;
            out_last  <= is_last;
            case (op)
              OP_READ: begin
                out_kind  <= RK_READ;
                out_x     <= '0;
                out_row   <= '0;
                out_color <= '0;
                out_on    <= 1'b0;
                out_rdata <= {mem_q, 5'b00000};
              end
              OP_SIMPLE: begin
                out_kind  <= simple_kind;
                out_x     <= '0;
                out_row   <= '0;
                out_color <= '0;
                out_on    <= 1'b0;
                out_rdata <= '0;
              end
              default: begin
                out_kind  <= RK_PLOT;
                out_x     <= addr[7:0];
                out_row   <= row[8:0];
                out_color <= pen;
                out_on    <= on_scr;
                out_rdata <= '0;
              end
            endcase
            if (is_last) begin
              state <= S_IDLE;
            end else begin
              addr <= addr + ADDR_W'(1);
              cnt  <= cnt + 3'd1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result.valid       = out_valid;
  assign result.result_kind = out_kind;
  assign result.pixel_x     = out_x;
  assign result.pixel_row   = out_row;
  assign result.pixel_color = out_color;
  assign result.on_screen   = out_on;
  assign result.read_data   = out_rdata;
  assign result.last_result = out_last;

endmodule
`default_nettype wire

// ===== rtl/core/abvrp_checker.sv =====
`default_nettype none
module abvrp_checker
  import abvrp_pkg::*;
(
  input wire       clk,
  input wire       rst,
  input wire       in_valid,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire [1:0] out_kind,
  input wire [7:0] out_x,
  input wire [2:0] out_color,
  input wire       out_last
);

  // one request at a time: the port closes right after a request
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken in back-to-back cycles");

  // more pixels pending: no new request may slip in
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> !in_ready)
    else $error("request taken while results still pending");

  // only plots come in groups
  a_group_is_plot: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> out_kind == RK_PLOT)
    else $error("non-plot result without last flag");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_x)
      && $stable(out_color) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind arcade_bitmap_video_ram_port_unit abvrp_checker u_abvrp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (request.valid),
  .in_ready  (request.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_kind  (result.result_kind),
  .out_x     (result.pixel_x),
  .out_color (result.pixel_color),
  .out_last  (result.last_result)
);
`default_nettype wire
